/* sv/heightmap_bilinear_sampler_defines.svh */
// Assertion macros for the heightmap sampler RTL.
// Files that carry concurrent assertions include this header; it needs nothing else.
`ifndef HEIGHTMAP_BILINEAR_SAMPLER_DEFINES_SVH
`define HEIGHTMAP_BILINEAR_SAMPLER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define HBS_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("heightmap sampler assertion failed");
`define HBS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("heightmap sampler assertion failed");
`else
`define HBS_ASSERT(label, prop)
`define HBS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

/* sv/hbs_pkg.sv */
// Shared constants, codes and types of the heightmap bilinear sampler.
// Used by hbs_grid_banks and heightmap_bilinear_sampler; depends on nothing.
package hbs_pkg;

   // Grid geometry and number formats.
   localparam int MAX_DIM     = 64;
   localparam int HEIGHT_BITS = 16;
   localparam int FRAC_BITS   = 8;

   localparam int IDX_W      = $clog2(MAX_DIM);
   localparam int DIM_W      = IDX_W + 1;
   localparam int HALF_W     = IDX_W - 1;
   localparam int BANK_AW    = 2 * HALF_W;
   localparam int BANK_DEPTH = (MAX_DIM / 2) * (MAX_DIM / 2);
   localparam int NUM_BANKS  = 4;
   localparam int BANK_SEL_W = 2;

   // Port field widths.
   localparam int ROW_W      = 6;
   localparam int COORD_W    = 24;
   localparam int INV_W      = 24;
   localparam int DIM_REG_W  = 7;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   // Datapath widths. The product of a Q17.8 difference and a Q8.16 reciprocal
   // carries 24 fraction bits.
   localparam int DIFF_W    = COORD_W + 1;
   localparam int PROD_W    = DIFF_W + INV_W + 1;
   localparam int PROD_FRAC = 24;
   localparam int IPART_W   = PROD_W - PROD_FRAC;
   localparam int WGT_W     = FRAC_BITS + 2;
   localparam int LERP_W    = HEIGHT_BITS + FRAC_BITS + 2;
   localparam int SUM_W     = LERP_W + FRAC_BITS + 2;
   localparam int QUOT_W    = SUM_W - 2 * FRAC_BITS;

   localparam logic signed [WGT_W-1:0] FULL_WEIGHT = WGT_W'(1 << FRAC_BITS);
   localparam logic signed [SUM_W-1:0] ROUND_HALF  = SUM_W'(1 << (2 * FRAC_BITS - 1));

   localparam logic [INV_W-1:0]     INV_STEP_RESET = INV_W'(65536);
   localparam logic [DIM_REG_W-1:0] GRID_DIM_RESET = DIM_REG_W'(64);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X   = 3'd0,
      CSR_ORIGIN_Y   = 3'd1,
      CSR_INV_STEP_X = 3'd2,
      CSR_INV_STEP_Y = 3'd3,
      CSR_GRID_ROWS  = 3'd4,
      CSR_GRID_COLS  = 3'd5
   } csr_reg_type;

   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

   // Grid index and fraction along one axis after clamping.
   typedef struct packed {
      logic [IDX_W-1:0]     idx;
      logic [FRAC_BITS-1:0] frac;
      logic                 at_edge;
   } axis_type;

   typedef struct packed {
      logic                   en;
      logic [BANK_SEL_W-1:0]  bank;
      logic [BANK_AW-1:0]     addr;
      logic [HEIGHT_BITS-1:0] data;
   } mem_wr_type;

   typedef struct packed {
      logic                              en;
      logic [NUM_BANKS-1:0][BANK_AW-1:0] addr;
   } mem_rd_type;

endpackage

/* sv/hbs_grid_banks.sv */
// Height grid split into four banks by row and column parity, one read each per cycle.
// Depends on hbs_pkg for geometry and the access structs.
module hbs_grid_banks
   import hbs_pkg::*;
(
   input  logic                                  clock,
   input  mem_wr_type                            wr,
   input  mem_rd_type                            rd,
   output logic [NUM_BANKS-1:0][HEIGHT_BITS-1:0] rd_data
);

   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      logic [HEIGHT_BITS-1:0] mem [BANK_DEPTH];
      logic [HEIGHT_BITS-1:0] q_ff;

      always_ff @(posedge clock) begin
         if (wr.en && (wr.bank == BANK_SEL_W'(b))) begin
            mem[wr.addr] <= wr.data;
         end
         if (rd.en) begin
            q_ff <= mem[rd.addr[b]];
         end
      end

      assign rd_data[b] = q_ff;
   end

endmodule

/* sv/heightmap_bilinear_sampler.sv */
// Top level of the heightmap bilinear sampler: pipeline, configuration and assertions.
// Depends on hbs_pkg, hbs_grid_banks and heightmap_bilinear_sampler_defines.svh.
//
// Channel  Dir  Handshake             Payload
// req      in   req_valid, req_stall  func, row_index, col_index, sample_value, query_x, query_y
// rsp      out  rsp_valid, rsp_stall  height_out
// csr      in   csr_valid, csr_ready  csr_index, csr_wdata
//
// One req per cycle unless stalled; a query passes stages 1 to 5 and the output register.
// The rate is set by the four parity banks of the grid, each read once per cycle.
// Reset clears the stage valid bits and the configuration registers; grid contents are not cleared.
// rsp_stall holds the output register; empty stages still fill, so req_stall rises
// only once every stage ahead of the input is occupied.
`include "heightmap_bilinear_sampler_defines.svh"

module heightmap_bilinear_sampler
   import hbs_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_func,
   input  logic [ROW_W-1:0]              req_row_index,
   input  logic [ROW_W-1:0]              req_col_index,
   input  logic signed [HEIGHT_BITS-1:0] req_sample_value,
   input  logic signed [COORD_W-1:0]     req_query_x,
   input  logic signed [COORD_W-1:0]     req_query_y,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [HEIGHT_BITS-1:0] rsp_height_out,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_DATA_W-1:0]         csr_wdata
);

   function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_REG_W-1:0] raw);
      logic [DIM_W-1:0] r;
      if (raw < DIM_REG_W'(2)) begin
         r = DIM_W'(2);
      end else if (int'(raw) > MAX_DIM) begin
         r = DIM_W'(MAX_DIM);
      end else begin
         r = DIM_W'(raw);
      end
      return r;
   endfunction

   // Negative coordinates go to index 0; anything past the grid goes to the
   // last index with no fraction.
   function automatic axis_type to_grid(input logic signed [PROD_W-1:0] p,
                                        input logic [DIM_W-1:0] dim);
      axis_type r;
      logic [IPART_W-1:0] ipart;
      logic [DIM_W-1:0] nxt;
      ipart = p[PROD_W-1:PROD_FRAC];
      if (p[PROD_W-1]) begin
         r.idx  = '0;
         r.frac = '0;
      end else if (ipart >= IPART_W'(dim)) begin
         r.idx  = IDX_W'(dim - DIM_W'(1));
         r.frac = '0;
      end else begin
         r.idx  = ipart[IDX_W-1:0];
         r.frac = p[PROD_FRAC-1 -: FRAC_BITS];
      end
      nxt = {1'b0, r.idx} + DIM_W'(1);
      r.at_edge = (nxt >= dim);
      return r;
   endfunction

   // Configuration registers.
   logic signed [COORD_W-1:0] origin_x_ff, origin_y_ff;
   logic [INV_W-1:0]          inv_x_ff, inv_y_ff;
   logic [DIM_W-1:0]          dim_x_ff, dim_y_ff;

   // Pipeline valid bits and stage enables.
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, rsp_valid_ff;
   logic en1, en2, en3, en4, en5, en_out;

   // Stage 1: differences and write fields.
   logic                          func1_ff;
   logic [ROW_W-1:0]              row1_ff, col1_ff;
   logic signed [HEIGHT_BITS-1:0] sample1_ff;
   logic signed [DIFF_W-1:0]      dx1_ff, dy1_ff;

   // Stage 2: grid-space products and write fields.
   logic                          func2_ff;
   logic [ROW_W-1:0]              row2_ff, col2_ff;
   logic signed [HEIGHT_BITS-1:0] sample2_ff;
   logic signed [PROD_W-1:0]      px2_ff, py2_ff;
   logic signed [PROD_W-1:0]      px_in, py_in;
   axis_type                      ax, ay;

   // Stage 3: fractions and neighbor selection; grid data arrives here.
   logic [FRAC_BITS-1:0] fx3_ff, fy3_ff;
   logic                 ix0_ff, iy0_ff, xedge_ff, yedge_ff;

   // Stage 4 and 5: blend partial sums.
   logic signed [LERP_W-1:0] a4_ff, b4_ff;
   logic [FRAC_BITS-1:0]     fy4_ff;
   logic signed [SUM_W-1:0]  sum5_ff;

   logic signed [HEIGHT_BITS-1:0] height_ff, height_in;

   mem_wr_type                            mem_wr;
   mem_rd_type                            mem_rd;
   logic [NUM_BANKS-1:0][HEIGHT_BITS-1:0] rd_data;

   // Each stage moves when it is empty or the stage after it moves.
   assign en_out    = !rsp_valid_ff || !rsp_stall;
   assign en5       = !v5_ff || en_out;
   assign en4       = !v4_ff || en5;
   assign en3       = !v3_ff || en4;
   assign en2       = !v2_ff || en3;
   assign en1       = !v1_ff || en2;
   assign req_stall = !en1;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         inv_x_ff    <= INV_STEP_RESET;
         inv_y_ff    <= INV_STEP_RESET;
         dim_x_ff    <= eff_dim(GRID_DIM_RESET);
         dim_y_ff    <= eff_dim(GRID_DIM_RESET);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_ORIGIN_X:   origin_x_ff <= $signed(csr_wdata[COORD_W-1:0]);
            CSR_ORIGIN_Y:   origin_y_ff <= $signed(csr_wdata[COORD_W-1:0]);
            CSR_INV_STEP_X: inv_x_ff    <= csr_wdata[INV_W-1:0];
            CSR_INV_STEP_Y: inv_y_ff    <= csr_wdata[INV_W-1:0];
            CSR_GRID_ROWS:  dim_x_ff    <= eff_dim(csr_wdata[DIM_REG_W-1:0]);
            CSR_GRID_COLS:  dim_y_ff    <= eff_dim(csr_wdata[DIM_REG_W-1:0]);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en1) begin
            v1_ff <= req_valid;
         end
         if (en2) begin
            v2_ff <= v1_ff;
         end
         // Sample writes retire into the grid when they leave stage 2.
         if (en3) begin
            v3_ff <= v2_ff && (func2_ff == FUNC_QUERY);
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
         if (en5) begin
            v5_ff <= v4_ff;
         end
         if (en_out) begin
            rsp_valid_ff <= v5_ff;
         end
      end
   end

   assign px_in = dx1_ff * $signed({1'b0, inv_x_ff});
   assign py_in = dy1_ff * $signed({1'b0, inv_y_ff});

   always_ff @(posedge clock) begin
      if (en1) begin
         func1_ff   <= req_func;
         row1_ff    <= req_row_index;
         col1_ff    <= req_col_index;
         sample1_ff <= req_sample_value;
         dx1_ff     <= DIFF_W'(req_query_x) - DIFF_W'(origin_x_ff);
         dy1_ff     <= DIFF_W'(req_query_y) - DIFF_W'(origin_y_ff);
      end
      if (en2) begin
         func2_ff   <= func1_ff;
         row2_ff    <= row1_ff;
         col2_ff    <= col1_ff;
         sample2_ff <= sample1_ff;
         px2_ff     <= px_in;
         py2_ff     <= py_in;
      end
   end

   assign ax = to_grid(px2_ff, dim_x_ff);
   assign ay = to_grid(py2_ff, dim_y_ff);

   // Writes and reads use the grid at the same stage, so they reach it in
   // transfer order and no forwarding is needed.
   always_comb begin
      logic [BANK_SEL_W-1:0] bsel;
      logic [HALF_W-1:0]     xa, ya;
      mem_wr.en   = v2_ff && en3 && (func2_ff == FUNC_WRITE) && (int'(row2_ff) < MAX_DIM)
                    && (int'(col2_ff) < MAX_DIM);
      mem_wr.bank = {row2_ff[0], col2_ff[0]};
      mem_wr.addr = {row2_ff[IDX_W-1:1], col2_ff[IDX_W-1:1]};
      mem_wr.data = sample2_ff;
      mem_rd.en   = v2_ff && en3 && (func2_ff == FUNC_QUERY);
      for (int b = 0; b < NUM_BANKS; b++) begin
         bsel = BANK_SEL_W'(b);
         // The bank of the other parity holds the next index up.
         xa = ax.idx[IDX_W-1:1] + HALF_W'(ax.idx[0] & ~bsel[1]);
         ya = ay.idx[IDX_W-1:1] + HALF_W'(ay.idx[0] & ~bsel[0]);
         mem_rd.addr[b] = {xa, ya};
      end
   end

   hbs_grid_banks u_grid (
      .clock   (clock),
      .wr      (mem_wr),
      .rd      (mem_rd),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (en3) begin
         fx3_ff   <= ax.frac;
         fy3_ff   <= ay.frac;
         ix0_ff   <= ax.idx[0];
         iy0_ff   <= ay.idx[0];
         xedge_ff <= ax.at_edge;
         yedge_ff <= ay.at_edge;
      end
   end

   // At the last index the missing neighbor reuses the edge sample, which
   // lives in the same bank as the sample itself.
   logic                          x1p, y1p;
   logic signed [HEIGHT_BITS-1:0] f00, f10, f01, f11;
   logic signed [WGT_W-1:0]       wx0, wx1, wy0, wy1;
   logic signed [LERP_W-1:0]      pa0, pa1, pb0, pb1;
   logic signed [SUM_W-1:0]       sa, sb;

   assign x1p = xedge_ff ? ix0_ff : ~ix0_ff;
   assign y1p = yedge_ff ? iy0_ff : ~iy0_ff;
   assign f00 = rd_data[{ix0_ff, iy0_ff}];
   assign f10 = rd_data[{x1p, iy0_ff}];
   assign f01 = rd_data[{ix0_ff, y1p}];
   assign f11 = rd_data[{x1p, y1p}];

   assign wx1 = $signed({2'b00, fx3_ff});
   assign wx0 = FULL_WEIGHT - wx1;
   assign pa0 = f00 * wx0;
   assign pa1 = f10 * wx1;
   assign pb0 = f01 * wx0;
   assign pb1 = f11 * wx1;

   always_ff @(posedge clock) begin
      if (en4) begin
         a4_ff  <= pa0 + pa1;
         b4_ff  <= pb0 + pb1;
         fy4_ff <= fy3_ff;
      end
   end

   assign wy1 = $signed({2'b00, fy4_ff});
   assign wy0 = FULL_WEIGHT - wy1;
   assign sa  = a4_ff * wy0;
   assign sb  = b4_ff * wy1;

   always_ff @(posedge clock) begin
      if (en5) begin
         sum5_ff <= sa + sb;
      end
   end

   // Round to nearest with ties upward, then saturate to the height range.
   always_comb begin
      logic signed [SUM_W-1:0]  t;
      logic [QUOT_W-1:0]        q;
      logic [QUOT_W-HEIGHT_BITS:0] hi;
      t  = sum5_ff + ROUND_HALF;
      q  = t[SUM_W-1:2*FRAC_BITS];
      hi = q[QUOT_W-1:HEIGHT_BITS-1];
      if ((&hi) || !(|hi)) begin
         height_in = q[HEIGHT_BITS-1:0];
      end else if (q[QUOT_W-1]) begin
         height_in = {1'b1, {(HEIGHT_BITS-1){1'b0}}};
      end else begin
         height_in = {1'b0, {(HEIGHT_BITS-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (en_out) begin
         height_ff <= height_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_height_out = height_ff;

   // Banks that hold no needed neighbor may return unwritten entries, so the
   // comparison is exact on unknown bits.
   `HBS_ASSERT(a_grid_single_access, !(mem_wr.en && mem_rd.en))
   `HBS_ASSERT_NEXT(a_read_data_held, v3_ff && !en4, $past(rd_data) === rd_data)
   `HBS_ASSERT(a_result_from_stage5, $rose(rsp_valid_ff) |-> $past(v5_ff))

endmodule
